### rtl/csc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the circle versus quad collision pipeline.
package csc_pkg;

    localparam int VERTEX_COUNT = 4;
    localparam int AXIS_COUNT   = VERTEX_COUNT + 1;
    localparam int IDX_WIDTH    = $clog2(VERTEX_COUNT);
    localparam int RADIUS_WIDTH = 15;
    localparam int AXIS_WIDTH   = 16;
    localparam int AXIS_FRAC    = 15;
    localparam int NORM_WIDTH   = 16;
    localparam int DIV_STEPS    = 30;
    localparam int QUOT_WIDTH   = DIV_STEPS + 1;
    localparam int SQRT_BITS    = 15;

    // Pipeline depths of the units.
    localparam int NEAR_LAT = 4;
    localparam int AXIS_LAT = 4 + (DIV_STEPS + 1) + SQRT_BITS + 1;
    localparam int PROJ_LAT = 4;

    typedef logic [IDX_WIDTH-1:0]         vidx_t;
    typedef logic signed [AXIS_WIDTH-1:0] axis_comp_t;

endpackage

### rtl/csc_nearest.sv
`timescale 1ns / 1ps
// Pipelined search for the vertex nearest to the circle center.
module csc_nearest #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] vx [0:csc_pkg::VERTEX_COUNT-1],
    input  logic signed [COORD_WIDTH-1:0] vy [0:csc_pkg::VERTEX_COUNT-1],
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    output csc_pkg::vidx_t                near
);
    import csc_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W:0]   dfx [0:VERTEX_COUNT-1];
    logic signed [W:0]   dfy [0:VERTEX_COUNT-1];
    logic [W-1:0]        mx_reg [0:VERTEX_COUNT-1];
    logic [W-1:0]        my_reg [0:VERTEX_COUNT-1];
    logic [2*W-1:0]      sqx_reg [0:VERTEX_COUNT-1];
    logic [2*W-1:0]      sqy_reg [0:VERTEX_COUNT-1];
    logic [2*W:0]        dist_reg [0:VERTEX_COUNT-1];
    logic [2*W:0]        best_a;
    logic [2*W:0]        best_b;
    vidx_t               idx_a;
    vidx_t               idx_b;
    vidx_t               near_reg;
    vidx_t               near_next;

    always_comb
    begin
        for (int i = 0; i < VERTEX_COUNT; i++)
        begin
            dfx[i] = (W+1)'(cx) - (W+1)'(vx[i]);
            dfy[i] = (W+1)'(cy) - (W+1)'(vy[i]);
        end
    end

    // Ties keep the lower index, since the left operand always has it.
    always_comb
    begin
        best_a = dist_reg[0];
        idx_a  = vidx_t'(0);
        if (dist_reg[1] < dist_reg[0])
        begin
            best_a = dist_reg[1];
            idx_a  = vidx_t'(1);
        end
        best_b = dist_reg[2];
        idx_b  = vidx_t'(2);
        if (dist_reg[3] < dist_reg[2])
        begin
            best_b = dist_reg[3];
            idx_b  = vidx_t'(3);
        end
        near_next = (best_b < best_a) ? idx_b : idx_a;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < VERTEX_COUNT; i++)
            begin
                mx_reg[i]   <= dfx[i][W] ? W'(-dfx[i]) : W'(dfx[i]);
                my_reg[i]   <= dfy[i][W] ? W'(-dfy[i]) : W'(dfy[i]);
                sqx_reg[i]  <= mx_reg[i] * mx_reg[i];
                sqy_reg[i]  <= my_reg[i] * my_reg[i];
                dist_reg[i] <= (2*W+1)'(sqx_reg[i]) + (2*W+1)'(sqy_reg[i]);
            end
            near_reg <= near_next;
        end
    end

    assign near = near_reg;

endmodule

### rtl/csc_axis_unit.sv
`timescale 1ns / 1ps
// One lane that turns a direction vector into a Q1.15 unit axis.
module csc_axis_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [COORD_WIDTH:0] dir_x,
    input  logic signed [COORD_WIDTH:0] dir_y,
    output csc_pkg::axis_comp_t         axis_x,
    output csc_pkg::axis_comp_t         axis_y,
    output logic                        axis_ok
);
    import csc_pkg::*;

    localparam int W         = COORD_WIDTH;
    localparam int SQW       = 2 * NORM_WIDTH;
    localparam int L2W       = SQW + 1;
    localparam int FLAG_LAST = AXIS_LAT - 1;

    function automatic logic [L2W:0] div_step(input logic [L2W-1:0] rem,
                                              input logic [L2W-1:0] d);
        logic [L2W:0] t;
        logic [L2W:0] dd;
        logic [L2W:0] diff;
        t    = {rem, 1'b0};
        dd   = {1'b0, d};
        diff = t - dd;
        if (t >= dd)
            return {1'b1, diff[L2W-1:0]};
        else
            return {1'b0, t[L2W-1:0]};
    endfunction

    function automatic logic [SQRT_BITS-1:0] sqrt_step(input logic [SQRT_BITS-1:0] root,
                                                       input logic [QUOT_WIDTH-1:0] q,
                                                       input int bitpos);
        logic [SQRT_BITS-1:0]   cand;
        logic [2*SQRT_BITS-1:0] sq;
        cand = root | (SQRT_BITS'(1) << bitpos);
        sq   = cand * cand;
        return ({1'b0, sq} <= q) ? cand : root;
    endfunction

    // Flags: nonzero direction, sign of x, sign of y.
    logic [2:0]            fl_reg [1:FLAG_LAST];
    logic [W-1:0]          ux_reg;
    logic [W-1:0]          uy_reg;
    logic [NORM_WIDTH-1:0] nx_next;
    logic [NORM_WIDTH-1:0] ny_next;
    logic [NORM_WIDTH-1:0] nx_reg;
    logic [NORM_WIDTH-1:0] ny_reg;
    logic [SQW-1:0]        sqx_reg;
    logic [SQW-1:0]        sqy_reg;
    logic [SQW-1:0]        numx_reg;
    logic [SQW-1:0]        numy_reg;
    logic [L2W-1:0]        l2_reg;
    logic [L2W-1:0]        dl2_reg [0:DIV_STEPS-1];
    logic [L2W-1:0]        remx_reg [0:DIV_STEPS];
    logic [L2W-1:0]        remy_reg [0:DIV_STEPS];
    logic [QUOT_WIDTH-1:0] quox_reg [0:DIV_STEPS];
    logic [QUOT_WIDTH-1:0] quoy_reg [0:DIV_STEPS];
    logic [QUOT_WIDTH-1:0] sqinx_reg [0:SQRT_BITS-2];
    logic [QUOT_WIDTH-1:0] sqiny_reg [0:SQRT_BITS-2];
    logic [SQRT_BITS-1:0]  rootx_reg [0:SQRT_BITS-1];
    logic [SQRT_BITS-1:0]  rooty_reg [0:SQRT_BITS-1];
    logic                  qx0;
    logic                  qy0;
    axis_comp_t            ax_reg;
    axis_comp_t            ay_reg;
    logic                  ok_reg;

    // Wide coordinates are scaled down together until both fit in 16 bits.
    generate
        if (W > NORM_WIDTH)
        begin : g_wide
            localparam int XW  = W - NORM_WIDTH;
            localparam int SHW = $clog2(XW + 1);
            logic [W-1:0]   orv;
            logic [SHW-1:0] sh;
            logic [W-1:0]   shx;
            logic [W-1:0]   shy;
            always_comb
            begin
                orv = ux_reg | uy_reg;
                sh  = '0;
                for (int i = 0; i < XW; i++)
                begin
                    if (orv[NORM_WIDTH+i])
                        sh = SHW'(i + 1);
                end
                shx = ux_reg >> sh;
                shy = uy_reg >> sh;
            end
            assign nx_next = shx[NORM_WIDTH-1:0];
            assign ny_next = shy[NORM_WIDTH-1:0];
        end
        else
        begin : g_narrow
            assign nx_next = NORM_WIDTH'(ux_reg);
            assign ny_next = NORM_WIDTH'(uy_reg);
        end
    endgenerate

    assign qx0 = ({1'b0, numx_reg} >= l2_reg);
    assign qy0 = ({1'b0, numy_reg} >= l2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg    <= dir_x[W] ? W'(-dir_x) : W'(dir_x);
            uy_reg    <= dir_y[W] ? W'(-dir_y) : W'(dir_y);
            fl_reg[1] <= {(dir_x != '0) || (dir_y != '0), dir_x[W], dir_y[W]};
            for (int k = 2; k <= FLAG_LAST; k++)
                fl_reg[k] <= fl_reg[k-1];

            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            sqx_reg  <= nx_reg * nx_reg;
            sqy_reg  <= ny_reg * ny_reg;
            l2_reg   <= L2W'(sqx_reg) + L2W'(sqy_reg);
            numx_reg <= sqx_reg;
            numy_reg <= sqy_reg;

            // The integer part of the quotient is at most one.
            remx_reg[0] <= qx0 ? ({1'b0, numx_reg} - l2_reg) : {1'b0, numx_reg};
            remy_reg[0] <= qy0 ? ({1'b0, numy_reg} - l2_reg) : {1'b0, numy_reg};
            quox_reg[0] <= {{(QUOT_WIDTH-1){1'b0}}, qx0};
            quoy_reg[0] <= {{(QUOT_WIDTH-1){1'b0}}, qy0};
            dl2_reg[0]  <= l2_reg;
            for (int k = 1; k < DIV_STEPS; k++)
                dl2_reg[k] <= dl2_reg[k-1];
        end
    end

    genvar gk;
    generate
        for (gk = 1; gk <= DIV_STEPS; gk++)
        begin : g_div
            logic [L2W:0] stx;
            logic [L2W:0] sty;
            assign stx = div_step(remx_reg[gk-1], dl2_reg[gk-1]);
            assign sty = div_step(remy_reg[gk-1], dl2_reg[gk-1]);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    remx_reg[gk] <= stx[L2W-1:0];
                    remy_reg[gk] <= sty[L2W-1:0];
                    quox_reg[gk] <= {quox_reg[gk-1][QUOT_WIDTH-2:0], stx[L2W]};
                    quoy_reg[gk] <= {quoy_reg[gk-1][QUOT_WIDTH-2:0], sty[L2W]};
                end
            end
        end

        // Root bits are decided from the top down; values past 32767 saturate.
        for (gk = 0; gk < SQRT_BITS; gk++)
        begin : g_sqrt
            logic [QUOT_WIDTH-1:0] qx;
            logic [QUOT_WIDTH-1:0] qy;
            logic [SQRT_BITS-1:0]  rx;
            logic [SQRT_BITS-1:0]  ry;
            if (gk == 0)
            begin : g_first
                assign qx = quox_reg[DIV_STEPS];
                assign qy = quoy_reg[DIV_STEPS];
                assign rx = '0;
                assign ry = '0;
            end
            else
            begin : g_rest
                assign qx = sqinx_reg[gk-1];
                assign qy = sqiny_reg[gk-1];
                assign rx = rootx_reg[gk-1];
                assign ry = rooty_reg[gk-1];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rootx_reg[gk] <= sqrt_step(rx, qx, SQRT_BITS - 1 - gk);
                    rooty_reg[gk] <= sqrt_step(ry, qy, SQRT_BITS - 1 - gk);
                end
            end
            if (gk < SQRT_BITS - 1)
            begin : g_pass
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        sqinx_reg[gk] <= qx;
                        sqiny_reg[gk] <= qy;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= fl_reg[FLAG_LAST][1] ? $signed(-{1'b0, rootx_reg[SQRT_BITS-1]})
                                           : $signed({1'b0, rootx_reg[SQRT_BITS-1]});
            ay_reg <= fl_reg[FLAG_LAST][0] ? $signed(-{1'b0, rooty_reg[SQRT_BITS-1]})
                                           : $signed({1'b0, rooty_reg[SQRT_BITS-1]});
            ok_reg <= fl_reg[FLAG_LAST][2];
        end
    end

    assign axis_x  = ax_reg;
    assign axis_y  = ay_reg;
    assign axis_ok = ok_reg;

endmodule

### rtl/csc_project.sv
`timescale 1ns / 1ps
// One lane that projects quad and circle onto an axis and tests the overlap.
module csc_project #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  csc_pkg::axis_comp_t           axis_x,
    input  csc_pkg::axis_comp_t           axis_y,
    input  logic                          axis_ok,
    input  logic signed [COORD_WIDTH-1:0] vx [0:csc_pkg::VERTEX_COUNT-1],
    input  logic signed [COORD_WIDTH-1:0] vy [0:csc_pkg::VERTEX_COUNT-1],
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic [csc_pkg::RADIUS_WIDTH-1:0] radius,
    output logic                          overlap
);
    import csc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int PW = W + AXIS_WIDTH;
    localparam int SW = PW + 1;
    localparam int RW = RADIUS_WIDTH + AXIS_FRAC;
    localparam int EW = ((SW > RW) ? SW : RW) + 2;

    function automatic logic signed [SW-1:0] smin(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [SW-1:0] smax(input logic signed [SW-1:0] a,
                                                  input logic signed [SW-1:0] b);
        return (b > a) ? b : a;
    endfunction

    logic signed [PW-1:0]   pvx_reg [0:VERTEX_COUNT-1];
    logic signed [PW-1:0]   pvy_reg [0:VERTEX_COUNT-1];
    logic signed [PW-1:0]   pcx_reg;
    logic signed [PW-1:0]   pcy_reg;
    logic signed [SW-1:0]   sum_reg [0:VERTEX_COUNT-1];
    logic signed [SW-1:0]   c_reg;
    logic signed [SW-1:0]   lo_reg;
    logic signed [SW-1:0]   hi_reg;
    logic signed [EW-1:0]   rr;
    logic signed [EW-1:0]   cm_reg;
    logic signed [EW-1:0]   cp_reg;
    logic [RADIUS_WIDTH-1:0] r1_reg;
    logic [RADIUS_WIDTH-1:0] r2_reg;
    logic                   ok1_reg;
    logic                   ok2_reg;
    logic                   ok3_reg;
    logic                   overlap_reg;

    assign rr = $signed(EW'({r2_reg, {AXIS_FRAC{1'b0}}}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < VERTEX_COUNT; i++)
            begin
                pvx_reg[i] <= axis_x * vx[i];
                pvy_reg[i] <= axis_y * vy[i];
                sum_reg[i] <= SW'(pvx_reg[i]) + SW'(pvy_reg[i]);
            end
            pcx_reg <= axis_x * cx;
            pcy_reg <= axis_y * cy;
            r1_reg  <= radius;
            ok1_reg <= axis_ok;

            c_reg   <= SW'(pcx_reg) + SW'(pcy_reg);
            r2_reg  <= r1_reg;
            ok2_reg <= ok1_reg;

            lo_reg  <= smin(smin(sum_reg[0], sum_reg[1]), smin(sum_reg[2], sum_reg[3]));
            hi_reg  <= smax(smax(sum_reg[0], sum_reg[1]), smax(sum_reg[2], sum_reg[3]));
            cm_reg  <= EW'(c_reg) - rr;
            cp_reg  <= EW'(c_reg) + rr;
            ok3_reg <= ok2_reg;

            // Touching intervals count as overlapping.
            overlap_reg <= ok3_reg && (EW'(hi_reg) >= cm_reg) && (cp_reg >= EW'(lo_reg));
        end
    end

    assign overlap = overlap_reg;

endmodule

### rtl/circle_quad_sat_collision.sv
`timescale 1ns / 1ps
// Top level of the circle versus convex quad separating axis collision test.
//
//   channel | handshake                  | payload
//   --------+----------------------------+-------------------------------------------
//   query   | query_valid / query_stall  | vertex0_x .. vertex3_y, center_x/y, radius
//   result  | result_valid / result_stall| colliding
//
// One query enters per cycle while query_stall is low.
// The depth is set by the axis lanes: a 31-step restoring divider and a 15-step root
// search per axis component, one step per stage, five lanes side by side.
// Reset clears only the valid bits of the pipeline and of the result register.
// A stalled result holds the pipeline only when the stage behind it carries a query;
// while that stage is empty, new queries keep flowing in.
module circle_quad_sat_collision #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                query_valid,
    output logic                                query_stall,
    input  logic signed [COORD_WIDTH-1:0]       vertex0_x,
    input  logic signed [COORD_WIDTH-1:0]       vertex0_y,
    input  logic signed [COORD_WIDTH-1:0]       vertex1_x,
    input  logic signed [COORD_WIDTH-1:0]       vertex1_y,
    input  logic signed [COORD_WIDTH-1:0]       vertex2_x,
    input  logic signed [COORD_WIDTH-1:0]       vertex2_y,
    input  logic signed [COORD_WIDTH-1:0]       vertex3_x,
    input  logic signed [COORD_WIDTH-1:0]       vertex3_y,
    input  logic signed [COORD_WIDTH-1:0]       center_x,
    input  logic signed [COORD_WIDTH-1:0]       center_y,
    input  logic [csc_pkg::RADIUS_WIDTH-1:0]    radius,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                colliding
);
    import csc_pkg::*;

    localparam int W        = COORD_WIDTH;
    localparam int ITEM_LAT = NEAR_LAT + AXIS_LAT;
    localparam int LAST     = ITEM_LAT + PROJ_LAT;

    logic signed [W-1:0]     in_vx [0:VERTEX_COUNT-1];
    logic signed [W-1:0]     in_vy [0:VERTEX_COUNT-1];
    logic signed [W-1:0]     vx_reg [0:ITEM_LAT][0:VERTEX_COUNT-1];
    logic signed [W-1:0]     vy_reg [0:ITEM_LAT][0:VERTEX_COUNT-1];
    logic signed [W-1:0]     cx_reg [0:ITEM_LAT];
    logic signed [W-1:0]     cy_reg [0:ITEM_LAT];
    logic [RADIUS_WIDTH-1:0] rad_reg [0:ITEM_LAT];
    logic [0:LAST]           vld_reg;
    logic                    res_vld_reg;
    logic                    colliding_reg;
    logic                    load;
    logic                    adv;
    vidx_t                   near;
    logic signed [W:0]       dir_x [0:AXIS_COUNT-1];
    logic signed [W:0]       dir_y [0:AXIS_COUNT-1];
    axis_comp_t              ax [0:AXIS_COUNT-1];
    axis_comp_t              ay [0:AXIS_COUNT-1];
    logic [AXIS_COUNT-1:0]   ax_ok;
    logic [AXIS_COUNT-1:0]   lane_ok;

    assign in_vx[0] = vertex0_x;
    assign in_vy[0] = vertex0_y;
    assign in_vx[1] = vertex1_x;
    assign in_vy[1] = vertex1_y;
    assign in_vx[2] = vertex2_x;
    assign in_vy[2] = vertex2_y;
    assign in_vx[3] = vertex3_x;
    assign in_vy[3] = vertex3_y;

    assign load        = !res_vld_reg || !result_stall;
    assign adv         = load || !vld_reg[LAST];
    assign query_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                vld_reg <= {query_valid, vld_reg[0:LAST-1]};
            if (load)
                res_vld_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vx_reg[0]  <= in_vx;
            vy_reg[0]  <= in_vy;
            cx_reg[0]  <= center_x;
            cy_reg[0]  <= center_y;
            rad_reg[0] <= radius;
            for (int k = 1; k <= ITEM_LAT; k++)
            begin
                vx_reg[k]  <= vx_reg[k-1];
                vy_reg[k]  <= vy_reg[k-1];
                cx_reg[k]  <= cx_reg[k-1];
                cy_reg[k]  <= cy_reg[k-1];
                rad_reg[k] <= rad_reg[k-1];
            end
        end
        if (load)
            colliding_reg <= &lane_ok;
    end

    csc_nearest #(
        .COORD_WIDTH(W)
    ) u_nearest (
        .clk (clk),
        .en  (adv),
        .vx  (vx_reg[0]),
        .vy  (vy_reg[0]),
        .cx  (cx_reg[0]),
        .cy  (cy_reg[0]),
        .near(near)
    );

    // Edge i runs from vertex i to the next one; its normal is (-ey, ex).
    genvar gi;
    generate
        for (gi = 0; gi < VERTEX_COUNT; gi++)
        begin : g_edge
            localparam int J = (gi + 1) % VERTEX_COUNT;
            assign dir_x[gi] = (W+1)'(vy_reg[NEAR_LAT][gi]) - (W+1)'(vy_reg[NEAR_LAT][J]);
            assign dir_y[gi] = (W+1)'(vx_reg[NEAR_LAT][J]) - (W+1)'(vx_reg[NEAR_LAT][gi]);
        end
    endgenerate

    assign dir_x[VERTEX_COUNT] = (W+1)'(cx_reg[NEAR_LAT]) - (W+1)'(vx_reg[NEAR_LAT][near]);
    assign dir_y[VERTEX_COUNT] = (W+1)'(cy_reg[NEAR_LAT]) - (W+1)'(vy_reg[NEAR_LAT][near]);

    generate
        for (gi = 0; gi < AXIS_COUNT; gi++)
        begin : g_lane
            csc_axis_unit #(
                .COORD_WIDTH(W)
            ) u_axis (
                .clk    (clk),
                .en     (adv),
                .dir_x  (dir_x[gi]),
                .dir_y  (dir_y[gi]),
                .axis_x (ax[gi]),
                .axis_y (ay[gi]),
                .axis_ok(ax_ok[gi])
            );

            csc_project #(
                .COORD_WIDTH(W)
            ) u_project (
                .clk    (clk),
                .en     (adv),
                .axis_x (ax[gi]),
                .axis_y (ay[gi]),
                .axis_ok(ax_ok[gi]),
                .vx     (vx_reg[ITEM_LAT]),
                .vy     (vy_reg[ITEM_LAT]),
                .cx     (cx_reg[ITEM_LAT]),
                .cy     (cy_reg[ITEM_LAT]),
                .radius (rad_reg[ITEM_LAT]),
                .overlap(lane_ok[gi])
            );
        end
    endgenerate

    assign result_valid = res_vld_reg;
    assign colliding    = colliding_reg;

endmodule

### rtl/csc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the collision block, bound to its top level.
module csc_checker (
    input logic clk,
    input logic rst_n,
    input logic query_valid,
    input logic query_stall,
    input logic result_valid,
    input logic result_stall,
    input logic colliding
);

    // A waiting result stays put until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(colliding))
        else $error("result changed while stalled");

    // A result only goes away through a completed transaction.
    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(!result_stall))
        else $error("result dropped without a transaction");

    // The query side only stalls while a result is held back by the consumer.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        query_stall |-> result_valid && result_stall)
        else $error("query stalled without a waiting result");

    a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !result_valid && !query_stall)
        else $error("pipeline not empty after reset");

endmodule

bind circle_quad_sat_collision csc_checker u_csc_checker (.*);
